@@ design/fpm_pkg.sv @@
// Shared types and constants for the fisheye pixel mapping pipeline.
// Holds the CORDIC angle table, fixed-point limits and register indexes.
// No dependencies.
package fpm_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int DW           = 34;
    localparam int RAD_W        = 19;
    localparam int DIV_R_BITS   = 18;
    localparam int NORM_BITS    = 16;
    localparam int PIX_BITS     = 13;

    typedef logic signed [DW-1:0]    cv_t;
    typedef logic signed [RAD_W-1:0] rad_t;

    localparam cv_t HALF_TURN    = 34'sd1073741824;
    localparam cv_t QUARTER_TURN = 34'sd536870912;
    localparam cv_t CORDIC_GAIN  = 34'sd652032874;

    localparam logic [31:0] PI_Q29 = 32'd1686629713;

    localparam rad_t R_MAX   = 19'sd262143;
    localparam rad_t R_MIN   = -19'sd262144;
    localparam rad_t ONE_Q16 = 19'sd65536;

    localparam int ATAN_TAB [CORDIC_STEPS] = '{
        268435456, 158466703, 83729453, 42502378, 21333666, 10677233, 5339919,
        2670123, 1335082, 667543, 333772, 166886, 83443, 41722, 20861, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3
    };

    localparam logic [2:0] CFG_CENTER_X      = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y      = 3'd1;
    localparam logic [2:0] CFG_CIRCLE_RADIUS = 3'd2;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd4;
    localparam logic [2:0] CFG_HALF_FOV      = 3'd5;
    localparam logic [2:0] CFG_LENS_POLY_ON  = 3'd6;
    localparam logic [2:0] CFG_LENS_COEFFS   = 3'd7;

endpackage

@@ design/fpm_cordic_cell.sv @@
// One CORDIC micro-rotation stage, rotation or vectoring mode.
// Depends on fpm_pkg for the vector type and the angle table.
module fpm_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fpm_pkg::cv_t      x_in,
    input  fpm_pkg::cv_t      y_in,
    input  fpm_pkg::cv_t      z_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output fpm_pkg::cv_t      x_out,
    output fpm_pkg::cv_t      y_out,
    output fpm_pkg::cv_t      z_out,
    output logic [SIDE_W-1:0] side_out
);
    import fpm_pkg::*;

    localparam cv_t ANGLE = cv_t'(ATAN_TAB[STEP]);

    cv_t  dx;
    cv_t  dy;
    logic turn_neg;

    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;
    // vectoring drives y toward zero, rotation drives z toward zero
    assign turn_neg = VECTOR ? ~y_in[DW-1] : z_in[DW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side_in;
            if (turn_neg)
            begin
                x_out <= x_in + dx;
                y_out <= y_in - dy;
                z_out <= z_in + ANGLE;
            end
            else
            begin
                x_out <= x_in - dx;
                y_out <= y_in + dy;
                z_out <= z_in - ANGLE;
            end
        end
    end

endmodule

@@ design/fpm_div_cell.sv @@
// One restoring division stage: settles a single quotient bit.
// No package dependency; the divisor is held steady by the caller.
module fpm_div_cell #(
    parameter int RW     = 34,
    parameter int DENW   = 16,
    parameter int QW     = 16,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DENW-1:0]   den,
    input  logic [RW-1:0]     rem_in,
    input  logic [QW-1:0]     q_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [RW-1:0]     rem_out,
    output logic [QW-1:0]     q_out,
    output logic [SIDE_W-1:0] side_out
);
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(den) << BIT;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side_in;
            rem_out  <= ge ? rem_in - trial : rem_in;
            q_out    <= q_in | (QW'(ge) << BIT);
        end
    end

endmodule

@@ design/fisheye_pixel_mapping.sv @@
// Top level of the fisheye pixel mapping pipeline.
// Depends on fpm_pkg, fpm_cordic_cell and fpm_div_cell.
//
// Usage:
//   s_* carries one latitude/longitude pair per beat; m_* returns one mapped
//   fisheye pixel per beat, in order. cfg_* writes the lens and image
//   registers; write them only while the pipeline is empty.
//   Throughput: one beat per clock unless the skid stage is full. The
//   datapath is a chain of cells: four 28-step CORDIC rows (lat/lon
//   sine/cosine side by side, two atan2 rows, theta sine/cosine), an
//   18-step divider row for the equidistant radius, four polynomial MAC
//   stages and two 16-step divider rows for the normalized coordinates.
//   Stall: the output register is backed by a one-beat skid stage. The
//   pipeline keeps taking input while a result waits; s_tready drops only
//   once the skid stage is full, and then the whole chain holds.
//   Reset: registers return to their documented defaults, all beats in
//   flight are dropped, s_tready comes up high.
//   Invalid rays (radius above one, off the image, zero image size) come
//   out with tuser low and all data fields zero.
module fisheye_pixel_mapping #(
    parameter int MAX_IMAGE_DIM = 8192,
    parameter int ANGLE_BITS    = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // latitude, longitude (ANGLE_BITS each, signed), zero padding
    input  logic [((2*ANGLE_BITS+7)/8)*8-1:0]             s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // pixel_u (13), pixel_v (13), norm_u (16), norm_v (16), zero padding
    output logic [63:0]                                   m_tdata,
    // valid_res
    output logic [0:0]                                    m_tuser,
    input  logic                                          cfg_wr_en,
    input  logic [2:0]                                    cfg_index,
    input  logic [63:0]                                   cfg_data
);
    import fpm_pkg::*;

    localparam int CS    = CORDIC_STEPS;
    localparam int ASH   = 31 - ANGLE_BITS;
    localparam int HFW   = 16 + ASH;
    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
    localparam int WW    = (DIM_W > 14) ? DIM_W : 14;
    localparam int ERW   = (HFW + 19 > 49) ? HFW + 19 : 49;
    localparam int GRW   = WW + 17;
    localparam int PHW   = 21;
    localparam int ACCW  = 36;
    localparam int ESW   = DW + PHW + 2;
    localparam int FSW   = RAD_W + 2;

    // ---------------- configuration registers ----------------
    logic [12:0] center_x_reg;
    logic [12:0] center_y_reg;
    logic [12:0] circle_radius_reg;
    logic [13:0] image_width_reg;
    logic [13:0] image_height_reg;
    logic [15:0] half_fov_reg;
    logic        lens_poly_on_reg;
    logic [63:0] lens_coeffs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            circle_radius_reg <= '0;
            image_width_reg   <= 14'd4096;
            image_height_reg  <= 14'd4096;
            half_fov_reg      <= 16'd16384;
            lens_poly_on_reg  <= 1'b0;
            lens_coeffs_reg   <= 64'd4096;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CENTER_X:      center_x_reg      <= cfg_data[12:0];
                CFG_CENTER_Y:      center_y_reg      <= cfg_data[12:0];
                CFG_CIRCLE_RADIUS: circle_radius_reg <= cfg_data[12:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[13:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[13:0];
                CFG_HALF_FOV:      half_fov_reg      <= cfg_data[15:0];
                CFG_LENS_POLY_ON:  lens_poly_on_reg  <= cfg_data[0];
                CFG_LENS_COEFFS:   lens_coeffs_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // derived constants; the user keeps them steady while beats are in flight, the block does not enforce it
    logic [WW-1:0]  w_eff;
    logic [WW-1:0]  h_eff;
    logic [HFW-1:0] hf;
    logic           size_zero;

    assign w_eff = (18'(image_width_reg) > 18'(MAX_IMAGE_DIM)) ? WW'(MAX_IMAGE_DIM)
                                                              : WW'(image_width_reg);
    assign h_eff = (18'(image_height_reg) > 18'(MAX_IMAGE_DIM)) ? WW'(MAX_IMAGE_DIM)
                                                               : WW'(image_height_reg);
    assign hf        = HFW'(half_fov_reg) << ASH;
    assign size_zero = (w_eff == '0) || (h_eff == '0);

    function automatic logic angle_folds(cv_t a);
        return (a > QUARTER_TURN) || (a < -QUARTER_TURN);
    endfunction

    function automatic cv_t fold_angle(cv_t a);
        cv_t r;
        if (a > QUARTER_TURN)
            r = a - HALF_TURN;
        else if (a < -QUARTER_TURN)
            r = a + HALF_TURN;
        else
            r = a;
        return r;
    endfunction

    // ---------------- flow control ----------------
    logic en;
    logic out_valid_reg;
    logic skid_valid_reg;

    // advance the whole chain unless the skid stage holds a beat
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    // ---------------- lat / lon sine and cosine ----------------
    cv_t lat_ext;
    cv_t lon_ext;

    assign lat_ext = cv_t'($signed(s_tdata[ANGLE_BITS-1:0])) <<< ASH;
    assign lon_ext = cv_t'($signed(s_tdata[2*ANGLE_BITS-1:ANGLE_BITS])) <<< ASH;

    logic a_v [0:CS];
    cv_t  a_x [0:CS];
    cv_t  a_y [0:CS];
    cv_t  a_z [0:CS];
    logic a_s [0:CS];
    logic b_v [0:CS];
    cv_t  b_x [0:CS];
    cv_t  b_y [0:CS];
    cv_t  b_z [0:CS];
    logic b_s [0:CS];

    assign a_v[0] = s_tvalid;
    assign a_x[0] = CORDIC_GAIN;
    assign a_y[0] = '0;
    assign a_z[0] = fold_angle(lat_ext);
    assign a_s[0] = angle_folds(lat_ext);
    assign b_v[0] = s_tvalid;
    assign b_x[0] = CORDIC_GAIN;
    assign b_y[0] = '0;
    assign b_z[0] = fold_angle(lon_ext);
    assign b_s[0] = angle_folds(lon_ext);

    for (genvar i = 0; i < CS; i++)
    begin : g_row_lat
        fpm_cordic_cell #(.STEP(i), .VECTOR(1'b0), .SIDE_W(1)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(a_v[i]), .x_in(a_x[i]), .y_in(a_y[i]), .z_in(a_z[i]),
            .side_in(a_s[i]),
            .out_valid(a_v[i+1]), .x_out(a_x[i+1]), .y_out(a_y[i+1]), .z_out(a_z[i+1]),
            .side_out(a_s[i+1])
        );
    end

    for (genvar i = 0; i < CS; i++)
    begin : g_row_lon
        fpm_cordic_cell #(.STEP(i), .VECTOR(1'b0), .SIDE_W(1)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(b_v[i]), .x_in(b_x[i]), .y_in(b_y[i]), .z_in(b_z[i]),
            .side_in(b_s[i]),
            .out_valid(b_v[i+1]), .x_out(b_x[i+1]), .y_out(b_y[i+1]), .z_out(b_z[i+1]),
            .side_out(b_s[i+1])
        );
    end

    // undo the quadrant fold, then form the view ray
    logic r1_v_reg;
    cv_t  cl_reg, sl_reg, co_reg, so_reg;
    logic r2_v_reg;
    cv_t  px_reg, py_reg, pz_reg;
    logic signed [2*DW-1:0] prod_px;
    logic signed [2*DW-1:0] prod_py;

    assign prod_px = cl_reg * so_reg;
    assign prod_py = cl_reg * co_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_v_reg <= 1'b0;
            r2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_v_reg <= a_v[CS] & b_v[CS];
            r2_v_reg <= r1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_reg <= a_s[CS] ? -a_x[CS] : a_x[CS];
            sl_reg <= a_s[CS] ? -a_y[CS] : a_y[CS];
            co_reg <= b_s[CS] ? -b_x[CS] : b_x[CS];
            so_reg <= b_s[CS] ? -b_y[CS] : b_y[CS];
            px_reg <= cv_t'(prod_px >>> 30);
            py_reg <= cv_t'(prod_py >>> 30);
            pz_reg <= sl_reg;
        end
    end

    // ---------------- theta = atan2(pz, px), rho = |(px, pz)| ----------------
    logic          c_v [0:CS];
    cv_t           c_x [0:CS];
    cv_t           c_y [0:CS];
    cv_t           c_z [0:CS];
    logic [DW:0]   c_s [0:CS];
    logic          c_zero;

    assign c_zero = (px_reg == '0) && (pz_reg == '0);
    assign c_v[0] = r2_v_reg;
    assign c_x[0] = px_reg[DW-1] ? -px_reg : px_reg;
    assign c_y[0] = px_reg[DW-1] ? -pz_reg : pz_reg;
    assign c_z[0] = px_reg[DW-1] ? (pz_reg[DW-1] ? -HALF_TURN : HALF_TURN) : cv_t'(0);
    assign c_s[0] = {py_reg, c_zero};

    for (genvar i = 0; i < CS; i++)
    begin : g_row_theta
        fpm_cordic_cell #(.STEP(i), .VECTOR(1'b1), .SIDE_W(DW+1)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(c_v[i]), .x_in(c_x[i]), .y_in(c_y[i]), .z_in(c_z[i]),
            .side_in(c_s[i]),
            .out_valid(c_v[i+1]), .x_out(c_x[i+1]), .y_out(c_y[i+1]), .z_out(c_z[i+1]),
            .side_out(c_s[i+1])
        );
    end

    logic                   c1_v_reg;
    logic                   c1_zero_reg;
    cv_t                    c1_theta_reg;
    cv_t                    c1_py_reg;
    logic signed [2*DW-1:0] c1_mag_reg;
    logic                   c2_v_reg;
    cv_t                    c2_theta_reg;
    cv_t                    c2_py_reg;
    cv_t                    c2_rho_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_v_reg <= c_v[CS];
            c2_v_reg <= c1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_zero_reg  <= c_s[CS][0];
            c1_py_reg    <= c_s[CS][DW:1];
            c1_theta_reg <= c_s[CS][0] ? cv_t'(0) : c_z[CS];
            c1_mag_reg   <= c_x[CS] * CORDIC_GAIN;
            c2_theta_reg <= c1_theta_reg;
            c2_py_reg    <= c1_py_reg;
            c2_rho_reg   <= c1_zero_reg ? cv_t'(0) : cv_t'(c1_mag_reg >>> 30);
        end
    end

    // ---------------- phi = atan2(rho, py) ----------------
    logic        d_v [0:CS];
    cv_t         d_x [0:CS];
    cv_t         d_y [0:CS];
    cv_t         d_z [0:CS];
    logic [DW:0] d_s [0:CS];
    logic        d_zero;

    assign d_zero = (c2_py_reg == '0) && (c2_rho_reg == '0);
    assign d_v[0] = c2_v_reg;
    assign d_x[0] = c2_py_reg[DW-1] ? -c2_py_reg : c2_py_reg;
    assign d_y[0] = c2_py_reg[DW-1] ? -c2_rho_reg : c2_rho_reg;
    assign d_z[0] = c2_py_reg[DW-1] ? (c2_rho_reg[DW-1] ? -HALF_TURN : HALF_TURN)
                                    : cv_t'(0);
    assign d_s[0] = {c2_theta_reg, d_zero};

    for (genvar i = 0; i < CS; i++)
    begin : g_row_phi
        fpm_cordic_cell #(.STEP(i), .VECTOR(1'b1), .SIDE_W(DW+1)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(d_v[i]), .x_in(d_x[i]), .y_in(d_y[i]), .z_in(d_z[i]),
            .side_in(d_s[i]),
            .out_valid(d_v[i+1]), .x_out(d_x[i+1]), .y_out(d_y[i+1]), .z_out(d_z[i+1]),
            .side_out(d_s[i+1])
        );
    end

    // magnitude of the second vectoring row is not needed
    logic d1_v_reg;
    cv_t  d1_theta_reg;
    cv_t  d1_phi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            d1_v_reg <= d_v[CS];
        end
    end

    // clip a slightly negative residue to zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_theta_reg <= d_s[CS][DW:1];
            d1_phi_reg   <= (d_s[CS][0] || d_z[CS][DW-1]) ? cv_t'(0) : d_z[CS];
        end
    end

    // ---------------- equidistant radius: phi * 2^16 / hf ----------------
    logic [63:0]     ph_prod;
    logic [PHW-1:0]  ph;
    logic [ERW-1:0]  e_num;
    logic            e_ovf;
    logic            e_gt;

    assign ph_prod = 64'(d1_phi_reg[31:0]) * 64'(PI_Q29);
    assign ph      = ph_prod[63:43];
    assign e_num   = ERW'(d1_phi_reg[31:0]) << 16;
    // quotient of 2^18 or more, or a zero divisor, saturates
    assign e_ovf   = (hf == '0) || (e_num >= (ERW'(hf) << DIV_R_BITS));
    assign e_gt    = 48'(d1_phi_reg[31:0]) > 48'(hf);

    logic                  e_v [0:DIV_R_BITS];
    logic [ERW-1:0]        e_r [0:DIV_R_BITS];
    logic [DIV_R_BITS-1:0] e_q [0:DIV_R_BITS];
    logic [ESW-1:0]        e_s [0:DIV_R_BITS];

    assign e_v[0] = d1_v_reg;
    assign e_r[0] = e_num;
    assign e_q[0] = '0;
    assign e_s[0] = {d1_theta_reg, ph, e_gt, e_ovf};

    for (genvar i = 0; i < DIV_R_BITS; i++)
    begin : g_row_rdiv
        fpm_div_cell #(
            .RW(ERW), .DENW(HFW), .QW(DIV_R_BITS), .BIT(DIV_R_BITS-1-i), .SIDE_W(ESW)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(e_v[i]), .den(hf), .rem_in(e_r[i]), .q_in(e_q[i]),
            .side_in(e_s[i]),
            .out_valid(e_v[i+1]), .rem_out(e_r[i+1]), .q_out(e_q[i+1]),
            .side_out(e_s[i+1])
        );
    end

    // ---------------- polynomial radius, Horner form ----------------
    typedef struct packed {
        cv_t                   theta;
        logic [PHW-1:0]        ph;
        logic                  gt;
        logic                  ovf;
        logic [DIV_R_BITS-1:0] q;
        logic [ACCW-1:0]       acc;
    } mac_t;

    function automatic logic [ACCW-1:0] coef16(logic [15:0] c);
        return {{(ACCW-20){c[15]}}, c, 4'b0};
    endfunction

    logic [ACCW-1:0] cf [0:3];
    mac_t            mac_src  [0:3];
    mac_t            mac_next [0:3];
    mac_t            mac_reg  [0:3];
    logic            mac_v_reg [0:3];

    assign cf[0] = coef16(lens_coeffs_reg[47:32]);
    assign cf[1] = coef16(lens_coeffs_reg[31:16]);
    assign cf[2] = coef16(lens_coeffs_reg[15:0]);
    assign cf[3] = '0;

    assign mac_src[0] = '{theta: e_s[DIV_R_BITS][ESW-1 -: DW],
                          ph:    e_s[DIV_R_BITS][PHW+1:2],
                          gt:    e_s[DIV_R_BITS][1],
                          ovf:   e_s[DIV_R_BITS][0],
                          q:     e_q[DIV_R_BITS],
                          acc:   coef16(lens_coeffs_reg[63:48])};

    for (genvar k = 0; k < 4; k++)
    begin : g_mac
        logic signed [PHW+ACCW:0] prod;

        if (k > 0)
        begin : g_src
            assign mac_src[k] = mac_reg[k-1];
        end

        assign prod = $signed({1'b0, mac_src[k].ph}) * $signed(mac_src[k].acc);

        always_comb
        begin
            mac_next[k]     = mac_src[k];
            mac_next[k].acc = cf[k] + ACCW'(prod >>> 16);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mac_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                mac_v_reg[k] <= (k == 0) ? e_v[DIV_R_BITS] : mac_v_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mac_reg[k] <= mac_next[k];
            end
        end
    end

    // gain of ten beyond the field of view, clamp, pick the lens model
    logic signed [ACCW-1:0] r_poly;
    logic signed [ACCW+5:0] r_gain;
    rad_t                   r_clamp;
    rad_t                   r_div;
    rad_t                   r_sel;

    assign r_poly = $signed(mac_reg[3].acc);
    assign r_gain = mac_reg[3].gt ? r_poly * 6'sd10 : (ACCW+6)'(r_poly);

    always_comb
    begin
        if (r_gain > (ACCW+6)'(R_MAX))
            r_clamp = R_MAX;
        else if (r_gain < (ACCW+6)'(R_MIN))
            r_clamp = R_MIN;
        else
            r_clamp = rad_t'(r_gain);
    end

    assign r_div = mac_reg[3].ovf ? R_MAX : rad_t'({1'b0, mac_reg[3].q});
    assign r_sel = lens_poly_on_reg ? r_clamp : r_div;

    logic m5_v_reg;
    cv_t  m5_theta_reg;
    rad_t m5_r_reg;
    logic m5_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m5_v_reg <= mac_v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m5_theta_reg <= mac_reg[3].theta;
            m5_r_reg     <= r_sel;
            m5_bad_reg   <= r_sel > ONE_Q16;
        end
    end

    // ---------------- cos / sin of theta ----------------
    logic           f_v [0:CS];
    cv_t            f_x [0:CS];
    cv_t            f_y [0:CS];
    cv_t            f_z [0:CS];
    logic [FSW-1:0] f_s [0:CS];

    assign f_v[0] = m5_v_reg;
    assign f_x[0] = CORDIC_GAIN;
    assign f_y[0] = '0;
    assign f_z[0] = fold_angle(m5_theta_reg);
    assign f_s[0] = {m5_r_reg, m5_bad_reg, angle_folds(m5_theta_reg)};

    for (genvar i = 0; i < CS; i++)
    begin : g_row_cs
        fpm_cordic_cell #(.STEP(i), .VECTOR(1'b0), .SIDE_W(FSW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(f_v[i]), .x_in(f_x[i]), .y_in(f_y[i]), .z_in(f_z[i]),
            .side_in(f_s[i]),
            .out_valid(f_v[i+1]), .x_out(f_x[i+1]), .y_out(f_y[i+1]), .z_out(f_z[i+1]),
            .side_out(f_s[i+1])
        );
    end

    // ---------------- pixel position ----------------
    logic               f1_v_reg, f2_v_reg, f3_v_reg;
    cv_t                f1_ct_reg, f1_st_reg;
    logic signed [32:0] f1_rr_reg;
    logic               f1_bad_reg, f2_bad_reg;
    cv_t                f2_offu_reg, f2_offv_reg;
    cv_t                f3_fu_reg, f3_fv_reg;
    logic               f3_good_reg;
    rad_t               f_r;
    logic signed [DW+33:0] prod_u;
    logic signed [DW+33:0] prod_v;
    cv_t                fu;
    cv_t                fv;
    logic               fu_ok;
    logic               fv_ok;

    assign f_r    = $signed(f_s[CS][FSW-1:2]);
    assign prod_u = f1_rr_reg * f1_ct_reg;
    assign prod_v = f1_rr_reg * f1_st_reg;
    assign fu     = cv_t'({center_x_reg, 16'b0}) + f2_offu_reg;
    assign fv     = cv_t'({center_y_reg, 16'b0}) + f2_offv_reg;
    assign fu_ok  = ~fu[DW-1] && (fu[DW-1:16] < 18'(w_eff));
    assign fv_ok  = ~fv[DW-1] && (fv[DW-1:16] < 18'(h_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= f_v[CS];
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_ct_reg   <= f_s[CS][0] ? -f_x[CS] : f_x[CS];
            f1_st_reg   <= f_s[CS][0] ? -f_y[CS] : f_y[CS];
            f1_rr_reg   <= f_r * $signed({1'b0, circle_radius_reg});
            f1_bad_reg  <= f_s[CS][1];
            f2_offu_reg <= cv_t'(prod_u >>> 30);
            f2_offv_reg <= cv_t'(prod_v >>> 30);
            f2_bad_reg  <= f1_bad_reg;
            f3_fu_reg   <= fu;
            f3_fv_reg   <= fv;
            f3_good_reg <= ~f2_bad_reg && ~size_zero && fu_ok && fv_ok;
        end
    end

    // ---------------- normalized coordinates ----------------
    logic                   g_v [0:NORM_BITS];
    logic [GRW-1:0]         g_r [0:NORM_BITS];
    logic [NORM_BITS-1:0]   g_q [0:NORM_BITS];
    logic [PIX_BITS:0]      g_s [0:NORM_BITS];
    logic                   h_v [0:NORM_BITS];
    logic [GRW-1:0]         h_r [0:NORM_BITS];
    logic [NORM_BITS-1:0]   h_q [0:NORM_BITS];
    logic [PIX_BITS-1:0]    h_s [0:NORM_BITS];

    // drop the dividend of an invalid beat so the quotient stays in range
    assign g_v[0] = f3_v_reg;
    assign g_r[0] = f3_good_reg ? f3_fu_reg[GRW-1:0] : '0;
    assign g_q[0] = '0;
    assign g_s[0] = {f3_good_reg, f3_fu_reg[16 +: PIX_BITS]};
    assign h_v[0] = f3_v_reg;
    assign h_r[0] = f3_good_reg ? f3_fv_reg[GRW-1:0] : '0;
    assign h_q[0] = '0;
    assign h_s[0] = f3_fv_reg[16 +: PIX_BITS];

    for (genvar i = 0; i < NORM_BITS; i++)
    begin : g_row_norm
        fpm_div_cell #(
            .RW(GRW), .DENW(WW), .QW(NORM_BITS), .BIT(NORM_BITS-1-i), .SIDE_W(PIX_BITS+1)
        ) u_ucell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(g_v[i]), .den(w_eff), .rem_in(g_r[i]), .q_in(g_q[i]),
            .side_in(g_s[i]),
            .out_valid(g_v[i+1]), .rem_out(g_r[i+1]), .q_out(g_q[i+1]),
            .side_out(g_s[i+1])
        );

        fpm_div_cell #(
            .RW(GRW), .DENW(WW), .QW(NORM_BITS), .BIT(NORM_BITS-1-i), .SIDE_W(PIX_BITS)
        ) u_vcell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(h_v[i]), .den(h_eff), .rem_in(h_r[i]), .q_in(h_q[i]),
            .side_in(h_s[i]),
            .out_valid(h_v[i+1]), .rem_out(h_r[i+1]), .q_out(h_q[i+1]),
            .side_out(h_s[i+1])
        );
    end

    // ---------------- output register and skid stage ----------------
    logic        pipe_v;
    logic        pipe_good;
    logic [63:0] pipe_data;
    logic [63:0] out_data_reg;
    logic        out_user_reg;
    logic [63:0] skid_data_reg;
    logic        skid_user_reg;

    assign pipe_v    = g_v[NORM_BITS] & h_v[NORM_BITS];
    assign pipe_good = g_s[NORM_BITS][PIX_BITS];
    assign pipe_data = pipe_good ? {6'b0, h_q[NORM_BITS], g_q[NORM_BITS],
                                    h_s[NORM_BITS], g_s[NORM_BITS][PIX_BITS-1:0]}
                                 : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            // output slot frees up: refill from the skid stage first
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= en & pipe_v;
            end
        end
        else if (en && pipe_v)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
            else
            begin
                out_data_reg <= pipe_data;
                out_user_reg <= pipe_good;
            end
        end
        else if (en && pipe_v)
        begin
            skid_data_reg <= pipe_data;
            skid_user_reg <= pipe_good;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

endmodule
